@@ rtl/itl_pkg.sv @@
// Package for the interpolating table lookup.
// Field widths, item kind codes and the controller/datapath command and status structs.
package itl_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  // magnitude of a breakpoint difference always fits 32 bits
  localparam int MAG_W   = 32;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic wr;        // store the breakpoint of the accepted write item
    logic capture;   // latch entry number and weight of the accepted lookup
    logic rd_en;     // table read
    logic rd_hi;     // read the upper entry of the pair
    logic load_lo;   // latch lower entry
    logic load_div;  // form the difference, start the divider
    logic div_step;  // divider step; the last one loads the quotient
    logic load_mul;  // weight times step
    logic load_out;  // sum, saturate, into the output register
  } itl_cmd_t;

  typedef struct packed {
    logic div_done;  // the current divider step is the last one
  } itl_status_t;

endpackage

@@ rtl/itl_in_if.sv @@
// Input channel of the interpolating table lookup: valid/ready plus one input item.
// Depends on itl_pkg.
interface itl_in_if import itl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [INDEX_W-1:0]  entry_index;
  logic signed [VALUE_W-1:0] entry_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, kind, entry_index, entry_value, position, input ready);
  modport sink   (input valid, kind, entry_index, entry_value, position, output ready);
endinterface

@@ rtl/itl_out_if.sv @@
// Result channel of the interpolating table lookup: valid/ready plus one result item.
// Depends on itl_pkg.
interface itl_out_if import itl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] mapped_value;

  modport source (output valid, mapped_value, input ready);
  modport sink   (input valid, mapped_value, output ready);
endinterface

@@ rtl/interpolating_table_lookup.sv @@
// Piecewise-linear breakpoint table. Write items store one entry per cycle while idle.
// Lookup: two table reads through the one RAM read port, a reciprocal division of the entry
// difference by the span, the multiply, then the saturating add into the output register.
// No new item is taken during a lookup; the input is ready again in the same cycle as the result.
// A result not yet taken holds the last step and stalls the input.
// Reset (synchronous, active low) clears controller state and output valid; table not cleared.
module interpolating_table_lookup import itl_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int WEIGHT_BITS   = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  itl_in_if.sink    in_item,
  itl_out_if.source out_item
);

  itl_cmd_t    cmd;
  itl_status_t status;

  itl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_kind   (in_item.kind),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd),
    .status    (status)
  );

  itl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_entry_index   (in_item.entry_index),
    .in_entry_value   (in_item.entry_value),
    .in_position      (in_item.position),
    .out_mapped_value (out_item.mapped_value)
  );

endmodule

@@ rtl/itl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module itl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/itl_ctrl.sv @@
// Controller of the interpolating table lookup: sequences table reads, divider, multiply, output.
// Depends on itl_pkg.
module itl_ctrl import itl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output itl_cmd_t    cmd,
  input  itl_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_SUM
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOOKUP) begin
            cmd.capture = 1'b1;
            state_nxt   = S_RD_LO;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD_LO: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_hi   = 1'b1;
        cmd.load_lo = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_div = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        // wait until the previous result has left the output register
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_LOOKUP) |=> state_r == S_RD_LO)
    else $error("lookup accepted without starting the table read");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && !status.div_done |=> state_r == S_DIV)
    else $error("divider left before its last step");

  a_sum_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) && out_valid_r && !out_ready |=> (state_r == S_SUM) && out_valid_r)
    else $error("result overwrote a pending output");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_SUM)
    else $error("output valid raised outside the final step");

endmodule

@@ rtl/itl_dp.sv @@
// Datapath of the interpolating table lookup: breakpoint RAM, reciprocal divider
// by the span, weight multiply, saturating add and output register. Depends on itl_pkg, itl_ram.
module itl_dp import itl_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int WEIGHT_BITS   = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  itl_cmd_t                  cmd,
  output itl_status_t               status,
  input  logic [INDEX_W-1:0]        in_entry_index,
  input  logic signed [VALUE_W-1:0] in_entry_value,
  input  logic [POS_W-1:0]          in_position,
  output logic signed [VALUE_W-1:0] out_mapped_value
);

  localparam int AW       = $clog2(TABLE_ENTRIES);
  localparam int STEP_W   = MAG_W + 1;
  localparam int PROD_W   = STEP_W + WEIGHT_BITS + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int RECIP_SH = MAG_W + WEIGHT_BITS;
  localparam int PART_W   = 2 * MAG_W + 1;
  localparam int ACC_W    = PART_W + 1;
  localparam logic [63:0] SPAN_L = (64'd1 << WEIGHT_BITS) - 64'd1;
  // ceil(2^RECIP_SH / span) gives the exact quotient for every MAG_W-bit dividend;
  // its top bit is 2^MAG_W, so only the low part needs a multiplier
  localparam logic [63:0] RECIP    = ((64'd1 << RECIP_SH) + SPAN_L - 64'd1) / SPAN_L;
  localparam logic [MAG_W:0] RECIP_LO = (MAG_W + 1)'(RECIP - (64'd1 << MAG_W));

  // lookup capture
  logic [31:0]            idx_full, idx_sat, lo_full, wr_idx;
  logic                   is_last;
  logic [AW-1:0]          lo_r;
  logic                   last_r;
  logic [WEIGHT_BITS-1:0] weight_r;

  // table
  logic                   wr_ok;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_W-1:0]     rd_data;

  // operands, divider
  logic signed [VALUE_W-1:0] elo_r, base_r;
  logic signed [MAG_W:0]     diff, diff_abs;
  logic                      neg_r;
  logic [MAG_W-1:0]          mag_r;
  logic [MAG_W-1:0]          quo_r;
  logic [PART_W-1:0]         part_r;
  logic [ACC_W-1:0]          recip_acc;
  logic                      phase_r;

  // multiply, sum
  logic signed [STEP_W-1:0] step_s;
  logic signed [PROD_W-1:0] w_ext, s_ext, prod_r;
  logic signed [SUM_W-1:0]  sum;
  logic                     ovf;
  logic signed [VALUE_W-1:0] sat, mapped_r;

  assign idx_full = 32'(in_position) >> WEIGHT_BITS;
  assign idx_sat  = (idx_full >= 32'(TABLE_ENTRIES)) ? 32'(TABLE_ENTRIES - 1) : idx_full;
  assign is_last  = (idx_sat == 32'(TABLE_ENTRIES - 1));
  // the last entry extrapolates with the pair below it
  assign lo_full  = is_last ? idx_sat - 32'd1 : idx_sat;

  assign wr_idx  = 32'(in_entry_index);
  assign wr_ok   = cmd.wr && (wr_idx < 32'(TABLE_ENTRIES));
  assign rd_addr = cmd.rd_hi ? lo_r + AW'(1) : lo_r;

  itl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (in_entry_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign diff     = (MAG_W + 1)'($signed(rd_data)) - (MAG_W + 1)'(elo_r);
  assign diff_abs = diff[MAG_W] ? -diff : diff;

  // magnitude times the full reciprocal: the 2^MAG_W term is a shift
  assign recip_acc = {2'b00, mag_r, {MAG_W{1'b0}}} + ACC_W'(part_r);

  assign status.div_done = phase_r;

  assign step_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign w_ext  = PROD_W'($signed({1'b0, weight_r}));
  assign s_ext  = PROD_W'(step_s);

  assign sum = SUM_W'(base_r) + SUM_W'(prod_r);
  assign ovf = !((&sum[SUM_W-1:VALUE_W-1]) || !(|sum[SUM_W-1:VALUE_W-1]));
  assign sat = ovf ? (sum[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}})
                   : sum[VALUE_W-1:0];

  assign out_mapped_value = mapped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (cmd.load_div) begin
      phase_r <= 1'b0;
    end else if (cmd.div_step) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lo_r     <= lo_full[AW-1:0];
      last_r   <= is_last;
      weight_r <= in_position[WEIGHT_BITS-1:0];
    end
    if (cmd.load_lo) begin
      elo_r <= $signed(rd_data);
    end
    if (cmd.load_div) begin
      neg_r  <= diff[MAG_W];
      mag_r  <= diff_abs[MAG_W-1:0];
      base_r <= last_r ? $signed(rd_data) : elo_r;
    end else if (cmd.div_step) begin
      if (!phase_r) begin
        part_r <= PART_W'(mag_r) * PART_W'(RECIP_LO);
      end else begin
        quo_r <= MAG_W'(recip_acc >> RECIP_SH);
      end
    end
    if (cmd.load_mul) begin
      prod_r <= w_ext * s_ext;
    end
    if (cmd.load_out) begin
      mapped_r <= sat;
    end
  end

endmodule

@@ tb/interpolating_table_lookup_tb.sv @@
`timescale 1ns / 1ps
// Testbench for interpolating_table_lookup: breakpoint writes and lookups with random idling.
// The testbench predicts every lookup from its own copy of the table and checks each result.
// Depends on itl_pkg, itl_in_if, itl_out_if and the RTL top level.
module interpolating_table_lookup_tb;
  import itl_pkg::*;

  localparam int  CLK_PERIOD      = 12;
  localparam int  ENTRIES         = 1024;
  localparam int  WGT_BITS        = 6;
  localparam longint SPAN         = (longint'(1) << WGT_BITS) - 1;
  localparam int  RANDOM_ITEMS    = 950;
  localparam int  HOLD_OFF_CYCLES = 400;
  localparam int  DRAIN_CYCLES    = 48;
  localparam int  CYCLE_LIMIT     = 1000000;
  localparam int  REPORT_MAX      = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

  typedef struct packed {
    logic                      kind;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]          position;
  } table_item_t;

  logic clk;
  logic rst_n;

  itl_in_if  in_if ();
  itl_out_if out_if ();

  interpolating_table_lookup #(
    .TABLE_ENTRIES(ENTRIES),
    .WEIGHT_BITS  (WGT_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_item(out_if)
  );

  // testbench copy of the breakpoint table
  logic signed [VALUE_W-1:0] bp_table [ENTRIES];
  bit                        bp_written [ENTRIES];

  logic signed [VALUE_W-1:0] mapped_expect_q [$];
  logic signed [VALUE_W-1:0] mapped_want;

  int  mismatch_count;
  int  cycle_count;
  int  write_count;
  int  lookup_count;
  int  saturated_count;
  int  long_hold_count;
  int  last_write_index;
  bit  hold_off_req;
  bit  stall_free;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned pair_base(input int unsigned seg);
    // the last entry extrapolates with the step of the pair below it
    return (seg >= ENTRIES - 1) ? ENTRIES - 2 : seg;
  endfunction

  function automatic bit pair_ready(input int unsigned seg);
    int unsigned base;
    base = pair_base(seg);
    return bp_written[base] && bp_written[base + 1];
  endfunction

  function automatic logic signed [VALUE_W-1:0] interpolate(input logic [POS_W-1:0] pos,
                                                            output bit clipped);
    int unsigned seg;
    int unsigned base;
    longint      weight;
    longint      step;
    longint      acc;
    seg = pos >> WGT_BITS;
    if (seg >= ENTRIES) seg = ENTRIES - 1;
    base   = pair_base(seg);
    weight = longint'(pos & ((1 << WGT_BITS) - 1));
    // 33-bit difference, divided with truncation toward zero
    step   = (longint'(bp_table[base + 1]) - longint'(bp_table[base])) / SPAN;
    acc    = longint'(bp_table[seg]) + weight * step;
    clipped = 1'b0;
    if (acc > longint'(VALUE_MAX)) begin
      acc = longint'(VALUE_MAX);
      clipped = 1'b1;
    end else if (acc < longint'(VALUE_MIN)) begin
      acc = longint'(VALUE_MIN);
      clipped = 1'b1;
    end
    return acc[VALUE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- result side

  task automatic note_mismatch(input string what, input logic signed [VALUE_W-1:0] want,
                               input logic signed [VALUE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("[%0t] %s: expected %0d (0x%08h), got %0d (0x%08h)",
               $realtime, what, want, want, got, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mapped_expect_q.size() == 0) begin
        note_mismatch("result with no lookup pending", 'x, out_if.mapped_value);
      end else begin
        mapped_want = mapped_expect_q.pop_front();
        if (out_if.mapped_value !== mapped_want)
          note_mismatch("mapped_value", mapped_want, out_if.mapped_value);
      end
    end
  end

  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_ready_driver
    int gap;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk);
        hold_off_req = 1'b0;
        long_hold_count++;
      end else begin
        gap = pick_gap(stall_free);
        if (gap == 0) begin
          out_if.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_item(input table_item_t item);
    int  gap;
    bit  clipped;
    gap = pick_gap(stall_free);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= item.kind;
    in_if.entry_index <= item.entry_index;
    in_if.entry_value <= item.entry_value;
    in_if.position    <= item.position;
    do @(posedge clk); while (!in_if.ready);
    // accepted at this edge: update the prediction in acceptance order
    if (item.kind == KIND_LOOKUP) begin
      mapped_expect_q.push_back(interpolate(item.position, clipped));
      lookup_count++;
      if (clipped) saturated_count++;
    end else begin
      if (item.entry_index < ENTRIES) begin
        bp_table[item.entry_index]   = item.entry_value;
        bp_written[item.entry_index] = 1'b1;
      end
      write_count++;
    end
  endtask

  task automatic write_entry(input int unsigned idx, input logic signed [VALUE_W-1:0] value);
    table_item_t item;
    item.kind        = KIND_WRITE;
    item.entry_index = idx[INDEX_W-1:0];
    item.entry_value = value;
    item.position    = POS_W'($urandom);
    last_write_index = idx;
    send_item(item);
  endtask

  task automatic look_up(input logic [POS_W-1:0] pos);
    table_item_t item;
    item.kind        = KIND_LOOKUP;
    item.entry_index = INDEX_W'($urandom);
    item.entry_value = $urandom;
    item.position    = pos;
    send_item(item);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (mapped_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return VALUE_MAX;
    if (r < 20) return VALUE_MIN;
    if (r < 40) return $signed($urandom_range(0, 400)) - 200;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    write_entry(0, VALUE_MIN);
    write_entry(1, VALUE_MAX);      // full-range difference needs 33 bits
    write_entry(2, 0);
    write_entry(3, VALUE_MIN);
    write_entry(4, 0);
    write_entry(5, -100);           // small negative step truncates toward zero
    write_entry(6, -1);
    look_up({10'd0, 6'd0});
    look_up({10'd0, 6'd63});
    look_up({10'd1, 6'd31});
    look_up({10'd2, 6'd63});
    look_up({10'd4, 6'd63});
    look_up({10'd5, 6'd1});
    // last entry extrapolates past the top of the range
    write_entry(ENTRIES - 2, VALUE_MIN);
    write_entry(ENTRIES - 1, VALUE_MAX);
    look_up({10'd1023, 6'd0});
    look_up(16'hffff);
    look_up({10'd1022, 6'd63});
    // and past the bottom
    write_entry(ENTRIES - 2, VALUE_MAX);
    write_entry(ENTRIES - 1, VALUE_MIN);
    look_up(16'hffff);
    look_up({10'd1023, 6'd1});
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int          r;
    int unsigned seg;
    int unsigned idx;
    int          tries;
    logic [5:0]  weight;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 50) stall_free = ~stall_free;
      if (n % 200 == 199) wait_for_results();
      r = $urandom_range(0, 99);
      seg = $urandom_range(0, ENTRIES - 1);
      tries = 0;
      while (!pair_ready(seg) && tries < ENTRIES) begin
        seg = (seg + 1) % ENTRIES;
        tries++;
      end
      if (r < 65 && pair_ready(seg)) begin
        r = $urandom_range(0, 9);
        weight = (r == 0) ? 6'd0 : (r == 1) ? 6'd63 : 6'($urandom);
        look_up({seg[INDEX_W-1:0], weight});
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) idx = $urandom_range(0, ENTRIES - 1);
        else if (r < 80) idx = (last_write_index + (r[0] ? 1 : ENTRIES - 1)) % ENTRIES;
        else if (r < 90) idx = $urandom_range(0, 3);
        else idx = $urandom_range(ENTRIES - 4, ENTRIES - 1);
        write_entry(idx, random_value());
      end
    end
    stall_free = 1'b0;
    wait_for_results();
  endtask

  // output held off while lookups keep coming: the block has to stall its input
  task automatic test_output_backpressure();
    int unsigned seg;
    for (seg = 0; seg < ENTRIES && !pair_ready(seg); seg++) ;
    hold_off_req = 1'b1;
    stall_free   = 1'b1;
    for (int n = 0; n < 20; n++)
      look_up({seg[INDEX_W-1:0], 6'($urandom)});
    stall_free = 1'b0;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------- run

  initial begin : timeout_guard
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             mapped_expect_q.size());
    $display("interpolating_table_lookup: mismatch");
    $finish;
  end

  initial begin : main_sequence
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.kind        <= KIND_WRITE;
    in_if.entry_index <= '0;
    in_if.entry_value <= '0;
    in_if.position    <= '0;
    mismatch_count    = 0;
    hold_off_req      = 1'b0;
    stall_free        = 1'b0;
    last_write_index  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_output_backpressure();
    test_random_mix();

    if (mapped_expect_q.size() != 0)
      note_mismatch("lookup left without a result", mapped_expect_q[0], 'x);
    $display("run covered %0d breakpoint writes and %0d lookups (%0d saturated),",
             write_count, lookup_count, saturated_count);
    $display("with %0d long output hold-off(s) and random idling on both sides",
             long_hold_count);
    if (mismatch_count == 0) begin
      $display("interpolating_table_lookup: match");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("interpolating_table_lookup: mismatch");
    end
    $finish;
  end

endmodule
